// ----- rtl/rcpa_pkg.sv -----
package rcpa_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int AXIS_W = 10;
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 2;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [CFG_W-1:0]  t_cfg;
    typedef logic [AXIS_W-1:0] t_axis;
    typedef logic [IDX_W-1:0]  t_cfg_idx;

    // item function codes
    localparam t_func FUNC_THR_EDGE = 2'd0;
    localparam t_func FUNC_STR_EDGE = 2'd1;
    localparam t_func FUNC_EVAL     = 2'd2;

    // configuration register indexes
    localparam t_cfg_idx CFG_PULSE_MIN = 2'd0;
    localparam t_cfg_idx CFG_PULSE_MAX = 2'd1;
    localparam t_cfg_idx CFG_FAILSAFE  = 2'd2;

    localparam t_cfg PULSE_MIN_RST = 16'd900;
    localparam t_cfg PULSE_MAX_RST = 16'd2100;
    localparam t_cfg FAILSAFE_RST  = 16'd1000;

    localparam logic [15:0] IN_LO = 16'd1000;
    localparam logic [15:0] TZ_LO = 16'd1450;
    localparam logic [15:0] TZ_HI = 16'd1550;
    localparam t_axis       AX_MAX = 10'd1023;

    // span lengths of the steering and throttle maps
    localparam logic [15:0] STR_SPAN = 16'd1000;
    localparam logic [15:0] THR_SPAN = 16'd450;

    // x*1023/1000 = x + 23x/1000, x*1023/450 = 2x + 123x/450
    localparam logic [4:0]  STR_FRAC  = 5'd23;
    localparam logic [6:0]  THR_FRAC  = 7'd123;
    localparam int          RECIP_SH  = 26;
    localparam logic [31:0] STR_RECIP = 32'd67109;
    localparam logic [33:0] THR_RECIP = 34'd149131;

endpackage

// ----- rtl/rcpa_in_if.sv -----
interface rcpa_in_if
    import rcpa_pkg::*;
();
    logic  valid;
    logic  ready;
    t_func func;
    t_time time_us;
    logic  pin_level;
    t_time time_ms;

    modport source (output valid, output func, output time_us, output pin_level,
                    output time_ms, input ready);
    modport sink   (input valid, input func, input time_us, input pin_level,
                    input time_ms, output ready);
endinterface

// ----- rtl/rcpa_out_if.sv -----
interface rcpa_out_if
    import rcpa_pkg::*;
();
    logic  valid;
    logic  ready;
    t_axis steer_axis;
    t_axis accel_axis;
    t_axis brake_axis;
    logic  link_lamp;
    logic  axes_written;
    logic  failsafe_active;

    modport source (output valid, output steer_axis, output accel_axis,
                    output brake_axis, output link_lamp, output axes_written,
                    output failsafe_active, input ready);
    modport sink   (input valid, input steer_axis, input accel_axis,
                    input brake_axis, input link_lamp, input axes_written,
                    input failsafe_active, output ready);
endinterface

// ----- rtl/rc_pulse_to_axes_failsafe_unit.sv -----
// path: an accepted item is held and decoded in the input register; the result of an
// evaluate item is written to the result register, which drives the output channel
// throughput: one item per cycle while an evaluate item's result can be taken; the
// registers decouple the channels, so input is taken while a result waits unless an
// evaluate item is held; reset (synchronous, active low) clears the valid flags and
// decoder state and loads the default pulse window and failsafe interval
module rc_pulse_to_axes_failsafe_unit
    import rcpa_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  t_cfg_idx      i_cfg_idx,
    input  t_cfg          i_cfg_data,
    rcpa_in_if.sink       i_in,
    rcpa_out_if.source    o_out
);

    // configuration
    t_cfg  r_pulse_min;
    t_cfg  r_pulse_max;
    t_cfg  r_failsafe;

    // input register
    logic  r_s1_valid;
    t_func r_s1_func;
    t_time r_s1_time_us;
    logic  r_s1_pin_level;
    t_time r_s1_time_ms;

    // decoder state
    t_time r_thr_prev, n_thr_prev;
    t_time r_str_prev, n_str_prev;
    t_time r_thr_width, n_thr_width;
    t_time r_str_width, n_str_width;
    t_axis r_thr_level, n_thr_level;
    t_axis r_last_thr, n_last_thr;
    t_axis r_last_steer, n_last_steer;
    t_time r_last_valid_ms, n_last_valid_ms;
    t_axis r_ax_steer, n_ax_steer;
    t_axis r_ax_accel, n_ax_accel;
    t_axis r_ax_brake, n_ax_brake;

    // result register
    logic  r_out_valid;
    t_axis r_out_steer;
    t_axis r_out_accel;
    t_axis r_out_brake;
    logic  r_out_lamp;
    logic  r_out_written;
    logic  r_out_failsafe;

    logic  n_lamp;
    logic  n_written;
    logic  n_failsafe;

    logic  s1_has_out;
    logic  out_free;
    logic  s1_adv;

    // mapping datapath
    logic [15:0] ws;
    logic [15:0] wt;
    logic        str_ok;
    logic        thr_ok;
    logic [15:0] str_d;
    logic [9:0]  str_d10;
    logic [14:0] str_y;
    logic [31:0] str_p;
    t_axis       steer;
    logic        thr_below;
    logic        thr_above;
    logic [15:0] thr_d;
    logic [8:0]  thr_d9;
    logic [15:0] thr_y;
    logic [33:0] thr_p;
    t_axis       thr_val;
    t_time       ms_gap;

    assign s1_has_out = (r_s1_func == FUNC_EVAL);
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && (!s1_has_out || out_free);
    assign i_in.ready = !r_s1_valid || s1_adv;

    // steering map
    assign ws      = r_str_width[15:0];
    assign wt      = r_thr_width[15:0];
    assign str_ok  = (r_str_width > TIME_W'(r_pulse_min)) &&
                     (r_str_width < TIME_W'(r_pulse_max));
    assign thr_ok  = (r_thr_width > TIME_W'(r_pulse_min)) &&
                     (r_thr_width < TIME_W'(r_pulse_max));
    assign str_d   = ws - IN_LO;
    assign str_d10 = str_d[9:0];
    assign str_y   = 15'(str_d10) * 15'(STR_FRAC);
    assign str_p   = 32'(str_y) * STR_RECIP;

    always_comb begin
        if (ws <= IN_LO) begin
            steer = '0;
        end else if (str_d >= STR_SPAN) begin
            steer = AX_MAX;
        end else begin
            steer = str_d10 + AXIS_W'(str_p[RECIP_SH+4:RECIP_SH]);
        end
    end

    // throttle map, one shared divide for both sides of the dead zone
    assign thr_below = (wt < TZ_LO);
    assign thr_above = (wt > TZ_HI);
    assign thr_d     = thr_below ? (wt - IN_LO) : (wt - TZ_HI);
    assign thr_d9    = thr_d[8:0];
    assign thr_y     = 16'(thr_d9) * 16'(THR_FRAC);
    assign thr_p     = 34'(thr_y) * THR_RECIP;
    assign thr_val   = {thr_d9, 1'b0} + AXIS_W'(thr_p[RECIP_SH+6:RECIP_SH]);
    assign ms_gap    = r_s1_time_ms - r_last_valid_ms;

    always_comb begin
        n_thr_prev      = r_thr_prev;
        n_str_prev      = r_str_prev;
        n_thr_width     = r_thr_width;
        n_str_width     = r_str_width;
        n_thr_level     = r_thr_level;
        n_last_thr      = r_last_thr;
        n_last_steer    = r_last_steer;
        n_last_valid_ms = r_last_valid_ms;
        n_ax_steer      = r_ax_steer;
        n_ax_accel      = r_ax_accel;
        n_ax_brake      = r_ax_brake;
        n_lamp          = 1'b0;
        n_written       = 1'b0;
        n_failsafe      = 1'b0;
        case (r_s1_func)
            FUNC_THR_EDGE: begin
                if (!r_s1_pin_level) begin
                    n_thr_width = r_s1_time_us - r_thr_prev;
                end
                n_thr_prev = r_s1_time_us;
            end
            FUNC_STR_EDGE: begin
                if (!r_s1_pin_level) begin
                    n_str_width = r_s1_time_us - r_str_prev;
                end
                n_str_prev = r_s1_time_us;
            end
            FUNC_EVAL: begin
                if (str_ok && thr_ok) begin
                    n_last_valid_ms = r_s1_time_ms;
                    n_lamp          = 1'b1;
                    if (thr_below) begin
                        if (wt <= IN_LO) begin
                            n_thr_level = AX_MAX;
                        end else begin
                            n_thr_level = AX_MAX - thr_val;
                        end
                    end else if (thr_above) begin
                        if (thr_d >= THR_SPAN) begin
                            n_thr_level = AX_MAX;
                        end else begin
                            n_thr_level = thr_val;
                        end
                    end
                    if (n_thr_level != r_last_thr || steer != r_last_steer) begin
                        n_written  = 1'b1;
                        n_ax_steer = steer;
                        n_ax_accel = thr_below ? n_thr_level : '0;
                        n_ax_brake = thr_above ? n_thr_level : '0;
                    end
                    n_last_thr   = n_thr_level;
                    n_last_steer = steer;
                end else if (ms_gap > TIME_W'(r_failsafe)) begin
                    n_ax_steer = '0;
                    n_ax_accel = '0;
                    n_ax_brake = '0;
                    n_failsafe = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_min <= PULSE_MIN_RST;
            r_pulse_max <= PULSE_MAX_RST;
            r_failsafe  <= FAILSAFE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PULSE_MIN: r_pulse_min <= i_cfg_data;
                CFG_PULSE_MAX: r_pulse_max <= i_cfg_data;
                CFG_FAILSAFE:  r_failsafe  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_func      <= i_in.func;
            r_s1_time_us   <= i_in.time_us;
            r_s1_pin_level <= i_in.pin_level;
            r_s1_time_ms   <= i_in.time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_prev      <= '0;
            r_str_prev      <= '0;
            r_thr_width     <= '0;
            r_str_width     <= '0;
            r_thr_level     <= '0;
            r_last_thr      <= '0;
            r_last_steer    <= '0;
            r_last_valid_ms <= '0;
            r_ax_steer      <= '0;
            r_ax_accel      <= '0;
            r_ax_brake      <= '0;
        end else if (s1_adv) begin
            r_thr_prev      <= n_thr_prev;
            r_str_prev      <= n_str_prev;
            r_thr_width     <= n_thr_width;
            r_str_width     <= n_str_width;
            r_thr_level     <= n_thr_level;
            r_last_thr      <= n_last_thr;
            r_last_steer    <= n_last_steer;
            r_last_valid_ms <= n_last_valid_ms;
            r_ax_steer      <= n_ax_steer;
            r_ax_accel      <= n_ax_accel;
            r_ax_brake      <= n_ax_brake;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_has_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_has_out) begin
            r_out_steer    <= n_ax_steer;
            r_out_accel    <= n_ax_accel;
            r_out_brake    <= n_ax_brake;
            r_out_lamp     <= n_lamp;
            r_out_written  <= n_written;
            r_out_failsafe <= n_failsafe;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.steer_axis      = r_out_steer;
    assign o_out.accel_axis      = r_out_accel;
    assign o_out.brake_axis      = r_out_brake;
    assign o_out.link_lamp       = r_out_lamp;
    assign o_out.axes_written    = r_out_written;
    assign o_out.failsafe_active = r_out_failsafe;

    // a pass is either valid or timed out, never both
    a_lamp_vs_failsafe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_lamp && r_out_failsafe))
        else $error("link lamp and failsafe set in one result");

    // failsafe result carries zeroed axes
    a_failsafe_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_failsafe) |->
            (r_out_steer == '0 && r_out_accel == '0 && r_out_brake == '0))
        else $error("failsafe result with nonzero axes");

    // axes are rewritten only on a valid pass
    a_write_needs_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_written) |-> r_out_lamp)
        else $error("axes rewritten on an invalid pass");

    // accelerator and brake are never driven together
    a_accel_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ax_accel != '0 && r_ax_brake != '0))
        else $error("accelerator and brake both nonzero");

    // a held input item stays in the input register
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid)
        else $error("input item dropped while stalled");

endmodule
